@@ rtl/core/trs_model_matrix_builder_unit_macros.svh @@
// Assertion helpers for the model matrix builder.
`ifndef TRS_MODEL_MATRIX_BUILDER_UNIT_MACROS_SVH
`define TRS_MODEL_MATRIX_BUILDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/trs_mmb_pkg.sv @@
package trs_mmb_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int ATAN_ENTRIES      = 30;
    localparam int CW                = 34;   // CORDIC datapath width, Q2.30 plus headroom

    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic [2:0][CW-1:0] x;
        logic [2:0][CW-1:0] y;
        logic [2:0][CW-1:0] z;
        logic [2:0]         neg;
        logic [2:0][31:0]   pos;
        logic [2:0][31:0]   scale;
    } t_cord;

    typedef logic [22:0] t_frac_tab [45];

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] atan_val(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051D;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2E;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            24: v = 32'h00000028;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000002;
            29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // floor((m * 2^23 + 22) / 45), elaboration only
    function automatic t_frac_tab build_frac_tab();
        t_frac_tab tb;
        logic [63:0] num;
        for (int i = 0; i < 45; i++) begin
            num   = 64'(i) * 64'h800000 + 64'd22;
            tb[i] = 23'(num / 64'd45);
        end
        return tb;
    endfunction

    localparam t_frac_tab FRAC_TAB = build_frac_tab();

    // angle in 1/64 deg -> {negate flag, residual phase in 2^32-per-turn units}
    // phase = floor((a*2^32 + 11520) / 23040) = k*2^23 + floor((m*2^23 + 22)/45), a = 45k+m
    function automatic logic [CW:0] phase_of(input logic [15:0] ang);
        logic signed [16:0] a;
        logic [14:0]        ar;
        logic [25:0]        prod;
        logic [8:0]         k0;
        logic [8:0]         k;
        logic [6:0]         m0;
        logic [5:0]         m;
        logic [31:0]        p;
        logic [31:0]        zz;
        logic               neg;
        a = {ang[15], ang};
        if (a < 0) begin
            a = a + 17'sd23040;
            if (a < 0) begin
                a = a + 17'sd23040;
            end
        end else if (a >= 17'sd23040) begin
            a = a - 17'sd23040;
        end
        ar   = a[14:0];
        prod = 26'(ar) * 26'd1456;     // k0 is k or k-1
        k0   = prod[24:16];
        m0   = 7'(ar - 15'(k0) * 15'd45);
        if (m0 >= 7'd45) begin
            k = k0 + 9'd1;
            m = 6'(m0 - 7'd45);
        end else begin
            k = k0;
            m = m0[5:0];
        end
        p   = {k, FRAC_TAB[m]};
        neg = 1'b0;
        zz  = p;
        if ($signed(p) > 32'sd1073741824 || $signed(p) < -32'sd1073741824) begin
            neg = 1'b1;
            zz  = p ^ 32'h8000_0000;   // move by half a turn
        end
        return {neg, {(CW-32){zz[31]}}, zz};
    endfunction

endpackage

@@ rtl/core/trs_mmb_phase.sv @@
module trs_mmb_phase
    import trs_mmb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [2:0][31:0]  i_pos,
    input  logic [2:0][15:0]  i_angle,
    input  logic [2:0][31:0]  i_scale,
    output logic              o_vld,
    input  logic              i_rdy,
    output t_cord             o_data
);

    logic  r_vld;
    t_cord r_data;
    t_cord n_data;
    logic [CW:0] ph;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        n_data.pos   = i_pos;
        n_data.scale = i_scale;
        ph           = '0;
        for (int l = 0; l < 3; l++) begin
            ph            = phase_of(i_angle[l]);
            n_data.x[l]   = CORDIC_X0;
            n_data.y[l]   = '0;
            n_data.z[l]   = ph[CW-1:0];
            n_data.neg[l] = ph[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

@@ rtl/core/trs_mmb_cordic_cell.sv @@
module trs_mmb_cordic_cell
    import trs_mmb_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    output logic  o_rdy,
    input  t_cord i_data,
    output logic  o_vld,
    input  logic  i_rdy,
    output t_cord o_data
);

    localparam logic signed [CW-1:0] ATAN = $signed({{(CW-32){1'b0}}, atan_val(IDX)});

    logic  r_vld;
    t_cord r_data;
    t_cord n_data;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] zs;

    assign o_rdy = !r_vld || i_rdy;

    // one micro-rotation on all three lanes
    always_comb begin
        n_data = i_data;
        xs     = '0;
        ys     = '0;
        zs     = '0;
        for (int l = 0; l < 3; l++) begin
            xs = $signed(i_data.x[l]);
            ys = $signed(i_data.y[l]);
            zs = $signed(i_data.z[l]);
            if (!zs[CW-1]) begin
                n_data.x[l] = xs - (ys >>> IDX);
                n_data.y[l] = ys + (xs >>> IDX);
                n_data.z[l] = zs - ATAN;
            end else begin
                n_data.x[l] = xs + (ys >>> IDX);
                n_data.y[l] = ys - (xs >>> IDX);
                n_data.z[l] = zs + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

@@ rtl/core/trs_mmb_mat.sv @@
`include "trs_model_matrix_builder_unit_macros.svh"
module trs_mmb_mat
    import trs_mmb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  t_cord             i_data,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [11:0][31:0] o_ent
);

    localparam int F  = FRAC_BITS;
    localparam int SH = 30 - F;
    localparam int TW = F + 2;
    localparam int PW = 2 * TW;
    localparam int RW = PW + 2;
    localparam int EW = F + 3;
    localparam int VW = EW + 32;
    localparam int NS = 5;

    localparam logic signed [CW:0]   HALF_T = (CW+1)'(1) <<< (SH - 1);
    localparam logic signed [CW:0]   ONE_W  = (CW+1)'(1) <<< F;
    localparam logic signed [TW-1:0] ONE_T  = TW'(1) <<< F;
    localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (F - 1);
    localparam logic signed [RW-1:0] HALF_R = RW'(1) <<< (F - 1);
    localparam logic signed [VW-1:0] HALF_V = VW'(1) <<< (F - 1);
    localparam logic signed [VW-1:0] MAXV   = (VW'(1) <<< 31) - VW'(1);
    localparam logic signed [VW-1:0] MINV   = -(VW'(1) <<< 31);

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_rdy;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_rdy = en[0];
    assign o_vld = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: sign fix, round to FRAC_BITS, clamp to [-1, 1]
    logic signed [TW-1:0] r_c0 [3];
    logic signed [TW-1:0] r_s0 [3];
    logic signed [TW-1:0] n_c0 [3];
    logic signed [TW-1:0] n_s0 [3];
    logic [2:0][31:0]     r_pos0;
    logic [2:0][31:0]     r_sc0;
    logic signed [CW:0]   tx;
    logic signed [CW:0]   ty;
    logic signed [CW:0]   rx;
    logic signed [CW:0]   ry;

    always_comb begin
        tx = '0;
        ty = '0;
        rx = '0;
        ry = '0;
        for (int l = 0; l < 3; l++) begin
            tx = $signed({i_data.x[l][CW-1], i_data.x[l]});
            ty = $signed({i_data.y[l][CW-1], i_data.y[l]});
            if (i_data.neg[l]) begin
                tx = -tx;
                ty = -ty;
            end
            rx = (tx + HALF_T) >>> SH;
            ry = (ty + HALF_T) >>> SH;
            if (rx > ONE_W) begin
                rx = ONE_W;
            end else if (rx < -ONE_W) begin
                rx = -ONE_W;
            end
            if (ry > ONE_W) begin
                ry = ONE_W;
            end else if (ry < -ONE_W) begin
                ry = -ONE_W;
            end
            n_c0[l] = TW'(rx);
            n_s0[l] = TW'(ry);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0] && i_vld) begin
            for (int l = 0; l < 3; l++) begin
                r_c0[l] <= n_c0[l];
                r_s0[l] <= n_s0[l];
            end
            r_pos0 <= i_data.pos;
            r_sc0  <= i_data.scale;
        end
    end

    // stage 1: pair products, t and u
    logic signed [PW-1:0] p_sxsy;
    logic signed [PW-1:0] p_cxsy;
    logic signed [PW-1:0] r1_cycz;
    logic signed [PW-1:0] r1_cysz;
    logic signed [PW-1:0] r1_sxcy;
    logic signed [PW-1:0] r1_cxcy;
    logic signed [PW-1:0] r1_cxsz;
    logic signed [PW-1:0] r1_cxcz;
    logic signed [PW-1:0] r1_sxsz;
    logic signed [PW-1:0] r1_sxcz;
    logic signed [TW-1:0] r1_sy;
    logic signed [TW-1:0] r1_cz;
    logic signed [TW-1:0] r1_sz;
    logic signed [TW-1:0] r1_t;
    logic signed [TW-1:0] r1_u;
    logic [2:0][31:0]     r1_pos;
    logic [2:0][31:0]     r1_sc;

    always_comb begin
        p_sxsy = r_s0[0] * r_s0[1];
        p_cxsy = r_c0[0] * r_s0[1];
    end

    always_ff @(posedge i_clk) begin
        if (en[1] && r_vld[0]) begin
            r1_cycz <= r_c0[1] * r_c0[2];
            r1_cysz <= r_c0[1] * r_s0[2];
            r1_sxcy <= r_s0[0] * r_c0[1];
            r1_cxcy <= r_c0[0] * r_c0[1];
            r1_cxsz <= r_c0[0] * r_s0[2];
            r1_cxcz <= r_c0[0] * r_c0[2];
            r1_sxsz <= r_s0[0] * r_s0[2];
            r1_sxcz <= r_s0[0] * r_c0[2];
            r1_sy   <= r_s0[1];
            r1_cz   <= r_c0[2];
            r1_sz   <= r_s0[2];
            r1_t    <= TW'((p_sxsy + HALF_P) >>> F);
            r1_u    <= TW'((p_cxsy + HALF_P) >>> F);
            r1_pos  <= r_pos0;
            r1_sc   <= r_sc0;
        end
    end

    // stage 2: rotation entries, rounded to FRAC_BITS
    logic signed [RW-1:0] rr [9];
    logic signed [EW-1:0] r2_e [9];
    logic [2:0][31:0]     r2_pos;
    logic [2:0][31:0]     r2_sc;

    always_comb begin
        rr[0] = r1_cycz;
        rr[1] = -r1_cysz;
        rr[2] = r1_sy <<< F;
        rr[3] = r1_t * r1_cz + r1_cxsz;
        rr[4] = r1_cxcz - r1_t * r1_sz;
        rr[5] = -r1_sxcy;
        rr[6] = r1_sxsz - r1_u * r1_cz;
        rr[7] = r1_u * r1_sz + r1_sxcz;
        rr[8] = r1_cxcy;
    end

    always_ff @(posedge i_clk) begin
        if (en[2] && r_vld[1]) begin
            for (int k = 0; k < 9; k++) begin
                r2_e[k] <= EW'((rr[k] + HALF_R) >>> F);
            end
            r2_pos <= r1_pos;
            r2_sc  <= r1_sc;
        end
    end

    // stage 3: column scale
    logic signed [VW-1:0] r3_v [9];
    logic [2:0][31:0]     r3_pos;

    always_ff @(posedge i_clk) begin
        if (en[3] && r_vld[2]) begin
            for (int k = 0; k < 9; k++) begin
                r3_v[k] <= r2_e[k] * $signed(r2_sc[k % 3]);
            end
            r3_pos <= r2_pos;
        end
    end

    // stage 4: round, saturate, output register
    logic signed [VW-1:0] w [9];
    logic [31:0]          r4_out [9];
    logic [2:0][31:0]     r4_pos;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w[k] = (r3_v[k] + HALF_V) >>> F;
            if (w[k] > MAXV) begin
                w[k] = MAXV;
            end else if (w[k] < MINV) begin
                w[k] = MINV;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4] && r_vld[3]) begin
            for (int k = 0; k < 9; k++) begin
                r4_out[k] <= w[k][31:0];
            end
            r4_pos <= r3_pos;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                o_ent[r*4+c] = r4_out[r*3+c];
            end
            o_ent[r*4+3] = r4_pos[r];
        end
    end

    `TRS_ASSERT_IMP(a_trig_range, i_clk, i_rst_n, r_vld[0], (r_c0[0] <= ONE_T) && (r_c0[0] >= -ONE_T) && (r_s0[2] <= ONE_T) && (r_s0[2] >= -ONE_T), "trig value out of range")
    `TRS_ASSERT_IMP(a_drain_ready, i_clk, i_rst_n, !r_vld[NS-1], o_rdy, "empty output stage but input stalled")
    `TRS_ASSERT_NXT(a_advance, i_clk, i_rst_n, r_vld[0] && en[1], r_vld[1], "beat lost between stages")

endmodule

@@ rtl/core/trs_model_matrix_builder_unit.sv @@
// Model matrix builder: position, Euler angles and scale in, upper three
// rows of T*Rx*Ry*Rz*S out.
// Input channel: i_in_valid / o_in_ready, one beat per object. Output
// channel: o_out_valid / i_out_ready, one beat with twelve Q16.16 entries.
// Throughput: one beat per cycle when the receiver keeps up. The path
// runs through the phase stage, one CORDIC cell per stage (CORDIC_STAGES
// of them, capped at 30; 16 by default) and five matrix stages.
// Each stage holds its own valid bit and passes data on whenever the next
// stage is empty or moving, so bubbles close up.
// When the receiver stalls, the result holds on the output and the stages
// behind it keep filling; the input is refused only once every stage is full.
// Reset clears all valid bits; no result is pending after reset and the
// block takes input in the first cycle after it.
module trs_model_matrix_builder_unit
    import trs_mmb_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [15:0] i_angle_x,
    input  logic [15:0] i_angle_y,
    input  logic [15:0] i_angle_z,
    input  logic [31:0] i_scale_x,
    input  logic [31:0] i_scale_y,
    input  logic [31:0] i_scale_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_row0_col0,
    output logic [31:0] o_row0_col1,
    output logic [31:0] o_row0_col2,
    output logic [31:0] o_row0_col3,
    output logic [31:0] o_row1_col0,
    output logic [31:0] o_row1_col1,
    output logic [31:0] o_row1_col2,
    output logic [31:0] o_row1_col3,
    output logic [31:0] o_row2_col0,
    output logic [31:0] o_row2_col1,
    output logic [31:0] o_row2_col2,
    output logic [31:0] o_row2_col3
);

    localparam int N_CELLS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    t_cord             c_data [N_CELLS+1];
    logic              c_vld  [N_CELLS+1];
    logic              c_rdy  [N_CELLS+1];
    logic [11:0][31:0] ent;

    trs_mmb_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in_valid),
        .o_rdy   (o_in_ready),
        .i_pos   ({i_pos_z, i_pos_y, i_pos_x}),
        .i_angle ({i_angle_z, i_angle_y, i_angle_x}),
        .i_scale ({i_scale_z, i_scale_y, i_scale_x}),
        .o_vld   (c_vld[0]),
        .i_rdy   (c_rdy[0]),
        .o_data  (c_data[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        trs_mmb_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (c_vld[g]),
            .o_rdy   (c_rdy[g]),
            .i_data  (c_data[g]),
            .o_vld   (c_vld[g+1]),
            .i_rdy   (c_rdy[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    trs_mmb_mat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (c_vld[N_CELLS]),
        .o_rdy   (c_rdy[N_CELLS]),
        .i_data  (c_data[N_CELLS]),
        .o_vld   (o_out_valid),
        .i_rdy   (i_out_ready),
        .o_ent   (ent)
    );

    assign o_row0_col0 = ent[0];
    assign o_row0_col1 = ent[1];
    assign o_row0_col2 = ent[2];
    assign o_row0_col3 = ent[3];
    assign o_row1_col0 = ent[4];
    assign o_row1_col1 = ent[5];
    assign o_row1_col2 = ent[6];
    assign o_row1_col3 = ent[7];
    assign o_row2_col0 = ent[8];
    assign o_row2_col1 = ent[9];
    assign o_row2_col2 = ent[10];
    assign o_row2_col3 = ent[11];

endmodule
